>>> rtl/tlpvc_pkg.sv
// Shared constants and types for the tank level, pump and valve controller.
`default_nettype none

package tlpvc_pkg;

  localparam int unsigned HeightW  = 10;
  localparam int unsigned GapW     = 10;
  localparam int unsigned DistInW  = 16;
  localparam int unsigned DistW    = 11;
  localparam int unsigned FillW    = 8;
  localparam int unsigned ClsW     = 3;
  localparam int unsigned IconW    = 3;
  localparam int unsigned TicksW   = 5;

  // |diff| * 100 stays below 2**17 for any 10-bit gap and height
  localparam int unsigned DvdW     = 17;
  localparam int unsigned DvsW     = 10;
  localparam int unsigned DivSteps = DvdW;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  localparam logic [HeightW-1:0] HeightReset = HeightW'(400);
  localparam logic [GapW-1:0]    GapReset    = GapW'(20);
  localparam logic [TicksW-1:0]  BlinkPeriod = TicksW'(31);

  // Register indexes on the configuration port
  localparam logic RegTankHeight = 1'b0;
  localparam logic RegAirGap     = 1'b1;

  // Item kinds
  localparam logic ModeMeasure = 1'b0;
  localparam logic ModeTick    = 1'b1;

  // Level classes
  localparam logic [ClsW-1:0] ClsEmpty    = ClsW'(0);
  localparam logic [ClsW-1:0] ClsLow      = ClsW'(1);
  localparam logic [ClsW-1:0] ClsNormal   = ClsW'(2);
  localparam logic [ClsW-1:0] ClsFull     = ClsW'(3);
  localparam logic [ClsW-1:0] ClsOverflow = ClsW'(4);

  // Divider request and status between the sequencer and the divider unit
  typedef struct packed {
    logic                start;
    logic [DvdW-1:0]     dividend;
    logic [DvsW-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> rtl/tank_level_pump_valve_controller.sv
// Top level: sequencer, controller state, config registers and output register.
//
//  port group   dir  transaction carries
//  s_axis_*     in   tdata: distance_cm, valve_switch, pump_switch; tuser: mode
//  m_axis_*     out  tdata: clamped_distance .. led_red
//  cfg_*        in   register write, index 0 tank_height, 1 air_gap
//
// A measurement passes these steps: the clamp is taken at acceptance, StPrep forms
// |d - air_gap| * 100 and starts the divider, 17 divider steps run in StDiv, StDiv
// sees the divider finish, StDone commits. The next item can be taken in the cycle
// after the commit. A tick goes from acceptance straight to commit; no divider pass.
// The input side is ready only while no item is in flight; a result waiting
// in the output register does not block acceptance, only the next commit.
// Reset (async, active low) restores registers to 400 / 20 and clears flags.
`default_nettype none

module tank_level_pump_valve_controller
  import tlpvc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // distance_cm[15:0], valve_switch, pump_switch
  input  wire logic [0:0]  s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // clamped_distance[10:0], fill_percent[7:0],
                                          // level_class[2:0], level_icon[2:0],
                                          // valve_open, pump_running, led_green, led_red
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [9:0]  cfg_data_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPrep = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [HeightW-1:0]  height_q;
  logic [GapW-1:0]     gap_q;
  logic                valve_q, valve_d;
  logic                pump_q, pump_d;
  logic [TicksW-1:0]   ticks_q, ticks_d;
  logic                green_q, green_d;
  logic                red_q, red_d;

  logic                mode_q;
  logic [DistW-1:0]    dist_q;
  logic                vsw_q, psw_q;
  logic                neg_q, neg_d;

  logic                m_valid_q;
  logic [31:0]         m_data_q, m_data_d;

  logic                in_accept;
  logic                out_free;
  logic                commit;
  logic [DistW-1:0]    total;
  logic [DistW-1:0]    clamp;
  logic [DistW-1:0]    mag;
  logic [DvdW-1:0]     mag100;
  logic [DvsW-1:0]     h_eff;
  div_req_t            div_req;
  div_stat_t           div_stat;
  logic [DvdW-1:0]     quot;
  logic [FillW-1:0]    fill;
  logic                over;
  logic [ClsW-1:0]     cls;
  logic [IconW-1:0]    icon;
  logic [TicksW-1:0]   ticks_inc;
  logic [DistW-1:0]    res_dist;
  logic [FillW-1:0]    res_fill;
  logic [ClsW-1:0]     res_cls;
  logic [IconW-1:0]    res_icon;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign commit        = (state_q == StDone) && out_free;

  // clamp to the full tank depth on acceptance
  always_comb begin
    total = DistW'({1'b0, height_q} + {1'b0, gap_q});
    clamp = (s_axis_tdata[DistInW-1:0] > {{(DistInW-DistW){1'b0}}, total})
            ? total : s_axis_tdata[DistW-1:0];
  end

  // |d - gap| * 100 as shifts and adds
  always_comb begin
    neg_d  = dist_q < {1'b0, gap_q};
    mag    = neg_d ? DistW'({1'b0, gap_q} - dist_q) : DistW'(dist_q - {1'b0, gap_q});
    mag100 = DvdW'(({6'b0, mag} << 6) + ({6'b0, mag} << 5) + ({6'b0, mag} << 2));
    h_eff  = (height_q == '0) ? DvsW'(1) : height_q;
    div_req.start    = (state_q == StPrep);
    div_req.dividend = mag100;
    div_req.divisor  = h_eff;
  end

  tlpvc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .stat_o     (div_stat),
    .quotient_o (quot)
  );

  // 100 -/+ quotient, saturated to 0..255
  always_comb begin
    if (neg_q) begin
      fill = (quot > DvdW'(155)) ? FillW'(255) : FillW'(DvdW'(100) + quot);
    end else begin
      fill = (quot > DvdW'(100)) ? FillW'(0) : FillW'(DvdW'(100) - quot);
    end
    over = dist_q < {2'b0, gap_q[GapW-1:1]};
  end

  tlpvc_cls u_cls (
    .fill_i (fill),
    .over_i (over),
    .cls_o  (cls),
    .icon_o (icon)
  );

  always_comb begin
    state_d   = state_q;
    valve_d   = valve_q;
    pump_d    = pump_q;
    ticks_d   = ticks_q;
    green_d   = green_q;
    red_d     = red_q;
    ticks_inc = ticks_q + TicksW'(1);
    res_dist  = '0;
    res_fill  = '0;
    res_cls   = ClsEmpty;
    res_icon  = '0;

    if (mode_q == ModeMeasure) begin
      res_dist = dist_q;
      res_fill = fill;
      res_cls  = cls;
      res_icon = icon;
    end

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = (s_axis_tuser[0] == ModeTick) ? StDone : StPrep;
        end
      end
      StPrep: state_d = StDiv;
      StDiv: begin
        if (div_stat.done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
          if (mode_q == ModeMeasure) begin
            // LEDs follow the level only while the old flag is off
            if (!pump_q) begin
              green_d = (cls == ClsFull) || (cls == ClsOverflow);
            end
            if (!valve_q) begin
              red_d = (cls == ClsEmpty);
            end
            valve_d = over || vsw_q;
            pump_d  = (dist_q > {1'b0, gap_q}) && psw_q;
          end else if (valve_q || pump_q) begin
            ticks_d = ticks_inc;
            if (ticks_inc >= BlinkPeriod) begin
              ticks_d = '0;
              if (valve_q) begin
                red_d = !red_q;
              end
              if (pump_q) begin
                green_d = !green_q;
              end
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase

    m_data_d = {3'b0, red_d, green_d, pump_d, valve_d, res_icon, res_cls, res_fill, res_dist};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      height_q  <= HeightReset;
      gap_q     <= GapReset;
      valve_q   <= 1'b0;
      pump_q    <= 1'b0;
      ticks_q   <= '0;
      green_q   <= 1'b0;
      red_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valve_q <= valve_d;
      pump_q  <= pump_d;
      ticks_q <= ticks_d;
      green_q <= green_d;
      red_q   <= red_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegTankHeight: height_q <= cfg_data_i;
          RegAirGap:     gap_q    <= cfg_data_i;
          default:       height_q <= height_q;
        endcase
      end
      if (commit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= s_axis_tuser[0];
      dist_q <= clamp;
      vsw_q  <= s_axis_tdata[16];
      psw_q  <= s_axis_tdata[17];
    end
    if (state_q == StPrep) begin
      neg_q <= neg_d;
    end
    if (commit) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == StDiv))
    else $error("divider finished outside the divide state");

  a_div_busy_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (div_stat.busy || div_stat.done))
    else $error("divide state with an idle divider");

  a_ticks_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ticks_q != BlinkPeriod)
    else $error("blink counter reached its period without wrapping");

  a_measure_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (s_axis_tuser[0] == ModeMeasure)) |=> (state_q == StPrep))
    else $error("accepted measurement did not start preparation");
`endif

endmodule

`default_nettype wire

>>> rtl/tlpvc_div.sv
// Serial restoring divider: one quotient bit per cycle.
`default_nettype none

module tlpvc_div
  import tlpvc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire div_req_t        req_i,
  output div_stat_t            stat_o,
  output logic [DvdW-1:0]      quotient_o
);

  logic [DvsW-1:0]    rem_q, rem_d;
  logic [DvdW-1:0]    quo_q, quo_d;
  logic [DvsW-1:0]    dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DvsW:0]      trial;
  logic               fits;

  always_comb begin
    trial = {rem_q, quo_q[DvdW-1]};
    fits  = trial >= {1'b0, dvs_q};
  end

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = DivCntW'(DivSteps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract where the divisor fits
      rem_d = fits ? DvsW'(trial - {1'b0, dvs_q}) : trial[DvsW-1:0];
      quo_d = {quo_q[DvdW-2:0], fits};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

`default_nettype wire

>>> rtl/tlpvc_cls.sv
// Level class and fill icon from the fill percentage.
`default_nettype none

module tlpvc_cls
  import tlpvc_pkg::*;
(
  input  wire logic [FillW-1:0] fill_i,
  input  wire logic             over_i,
  output logic [ClsW-1:0]       cls_o,
  output logic [IconW-1:0]      icon_o
);

  always_comb begin
    priority if (fill_i > FillW'(99)) begin
      cls_o  = over_i ? ClsOverflow : ClsFull;
      icon_o = IconW'(5);
    end else if (fill_i > FillW'(9)) begin
      cls_o = ClsNormal;
      priority if (fill_i > FillW'(80)) begin
        icon_o = IconW'(5);
      end else if (fill_i > FillW'(60)) begin
        icon_o = IconW'(4);
      end else if (fill_i > FillW'(40)) begin
        icon_o = IconW'(3);
      end else if (fill_i > FillW'(20)) begin
        icon_o = IconW'(2);
      end else begin
        icon_o = IconW'(1);
      end
    end else if (fill_i != '0) begin
      cls_o  = ClsLow;
      icon_o = IconW'(1);
    end else begin
      cls_o  = ClsEmpty;
      icon_o = IconW'(0);
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/tank_status_checker.sv
// Checker for the tank controller: snoops both streams and the register port, predicts, compares.
`default_nettype none

module tank_status_checker
  import tlpvc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [23:0] in_data_i,   // distance_cm[15:0], valve_switch, pump_switch
  input  wire logic [0:0]  in_user_i,   // mode
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [31:0] out_data_i,  // clamped_distance[10:0], fill_percent[7:0],
                                        // level_class[2:0], level_icon[2:0],
                                        // valve_open, pump_running, led_green, led_red
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [9:0]  cfg_data_i,
  output int               mismatches_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]       pad;
    logic             red;
    logic             green;
    logic             pump;
    logic             valve;
    logic [IconW-1:0] icon;
    logic [ClsW-1:0]  cls;
    logic [FillW-1:0] fill;
    logic [DistW-1:0] clamped;
  } tank_status_t;

  logic [HeightW-1:0] height_q;
  logic [GapW-1:0]    gap_q;
  logic               valve_q;
  logic               pump_q;
  logic               green_q;
  logic               red_q;
  logic [TicksW-1:0]  ticks_q;
  tank_status_t       status_q[$];
  int                 mismatch_cnt = 0;

  // Advance the controller state by one item and return the status it reports.
  function automatic tank_status_t next_status(input logic mode,
                                               input logic [DistInW-1:0] dist_cm,
                                               input logic vsw, input logic psw);
    tank_status_t s;
    int           total;
    int           h;
    int           diff;
    int           fill;
    logic         over;
    s = '0;
    if (mode == ModeMeasure) begin
      total     = int'(height_q) + int'(gap_q);
      s.clamped = DistW'((int'(dist_cm) > total) ? total : int'(dist_cm));
      // zero height divides as one
      h      = (height_q == '0) ? 1 : int'(height_q);
      diff   = int'(s.clamped) - int'(gap_q);
      fill   = 100 - diff * 100 / h;
      if (fill < 0) fill = 0;
      if (fill > 255) fill = 255;
      s.fill = FillW'(fill);
      over   = int'(s.clamped) < int'(gap_q >> 1);
      if (fill > 99) begin
        s.cls  = over ? ClsOverflow : ClsFull;
        s.icon = 3'd5;
      end else if (fill > 9) begin
        s.cls = ClsNormal;
        if (fill > 80)      s.icon = 3'd5;
        else if (fill > 60) s.icon = 3'd4;
        else if (fill > 40) s.icon = 3'd3;
        else if (fill > 20) s.icon = 3'd2;
        else                s.icon = 3'd1;
      end else if (fill > 0) begin
        s.cls  = ClsLow;
        s.icon = 3'd1;
      end else begin
        s.cls  = ClsEmpty;
        s.icon = 3'd0;
      end
      // LEDs follow the flags as they were before this measurement
      if (!pump_q)  green_q = (s.cls == ClsFull) || (s.cls == ClsOverflow);
      if (!valve_q) red_q   = (s.cls == ClsEmpty);
      valve_q = over || vsw;
      pump_q  = (int'(s.clamped) > int'(gap_q)) && psw;
    end else if (valve_q || pump_q) begin
      if (ticks_q == BlinkPeriod - 1'b1) begin
        ticks_q = '0;
        if (valve_q) red_q   = !red_q;
        if (pump_q)  green_q = !green_q;
      end else begin
        ticks_q = ticks_q + 1'b1;
      end
    end
    s.valve = valve_q;
    s.pump  = pump_q;
    s.green = green_q;
    s.red   = red_q;
    return s;
  endfunction

  function automatic void check_field(input string label, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, label, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tank_status_t want;
    tank_status_t got;
    if (!rst_ni) begin
      height_q = HeightReset;
      gap_q    = GapReset;
      valve_q  = 1'b0;
      pump_q   = 1'b0;
      green_q  = 1'b0;
      red_q    = 1'b0;
      ticks_q  = '0;
      status_q.delete();
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegTankHeight) height_q = cfg_data_i;
        else                            gap_q    = cfg_data_i;
      end
      if (in_valid_i && in_ready_i)
        status_q.push_back(next_status(in_user_i[0], in_data_i[15:0], in_data_i[16],
                                       in_data_i[17]));
      if (out_valid_i && out_ready_i) begin
        got = tank_status_t'(out_data_i);
        if (status_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result with nothing expected: tdata %h", $realtime, out_data_i);
        end else begin
          want = status_q.pop_front();
          check_field("clamped_distance", 16'(want.clamped), 16'(got.clamped));
          check_field("fill_percent", 16'(want.fill), 16'(got.fill));
          check_field("level_class", 16'(want.cls), 16'(got.cls));
          check_field("level_icon", 16'(want.icon), 16'(got.icon));
          check_field("valve_open", 16'(want.valve), 16'(got.valve));
          check_field("pump_running", 16'(want.pump), 16'(got.pump));
          check_field("led_green", 16'(want.green), 16'(got.green));
          check_field("led_red", 16'(want.red), 16'(got.red));
          check_field("tdata padding", 16'(want.pad), 16'(got.pad));
        end
      end
      pending_o    <= status_q.size();
      mismatches_o <= mismatch_cnt;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Testbench top for the tank controller: clock, reset, stimulus, flow control and verdict.
`default_nettype none

module tb
  import tlpvc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we        = 1'b0;
  logic        cfg_idx       = RegTankHeight;
  logic [9:0]  cfg_data      = '0;

  int   mismatches;
  int   pending;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   cur_h     = 400;
  int   cur_g     = 20;
  logic hold_req  = 1'b0;
  logic hold_off  = 1'b0;

  tank_level_pump_valve_controller u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  tank_status_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // Long receiver hold-off, counted here so the sender keeps offering items.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
        hold_req <= 1'b0;
      end
    end
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // Present one item and hold it until the transaction completes; valid stays high after.
  task automatic send_item(input logic mode, input logic [15:0] dist_cm, input logic vsw,
                           input logic psw);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {6'b0, psw, vsw, dist_cm};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop valid and wait for every expected result.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_levels(input int h, input int g);
    cur_h = h;
    cur_g = g;
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= RegTankHeight;
    cfg_data <= 10'(h);
    @(posedge clk);
    cfg_idx  <= RegAirGap;
    cfg_data <= 10'(g);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic random_items(input int count);
    int          n;
    int          len;
    int          k;
    logic [15:0] d;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 30) begin
        // mostly short tick bursts, now and then a run long enough for a blink
        len = ($urandom_range(9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 3);
        repeat (len) send_item(ModeTick, 16'($urandom), 1'($urandom), 1'($urandom));
        n += len;
      end else begin
        case ($urandom_range(9))
          0: d = 16'($urandom);
          1, 2: begin
            k = ($urandom_range(1) ? cur_g / 2 : cur_g) + $urandom_range(4) - 2;
            d = 16'((k < 0) ? 0 : k);
          end
          3: begin
            k = cur_h + cur_g + $urandom_range(3) - 1;
            d = 16'((k < 0) ? 0 : k);
          end
          default: d = 16'($urandom_range(cur_h + cur_g + 4));
        endcase
        send_item(ModeMeasure, d, $urandom_range(99) < 30, $urandom_range(99) < 70);
        n++;
      end
    end
  endtask

  initial begin
    int set_h[12];
    int set_g[12];
    set_h = '{1, 1000, 0, 1023, 400, 37, -1, 1, -1, 1000, -1, 400};
    set_g = '{0, 1000, 7, 1023, 20, 500, -1, 1000, -1, 0, -1, 20};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at the reset levels: height 400, gap 20.
    send_item(ModeMeasure, 16'd0, 1'b0, 1'b1);      // overflow, valve forced open
    send_item(ModeTick, 16'hFFFF, 1'b1, 1'b1);
    send_item(ModeMeasure, 16'd9, 1'b0, 1'b0);      // last overflow distance
    send_item(ModeMeasure, 16'd10, 1'b0, 1'b0);     // full, over 100 percent
    send_item(ModeTick, 16'd0, 1'b0, 1'b0);         // no flag active, counter holds
    send_item(ModeMeasure, 16'd20, 1'b0, 1'b1);     // at the gap, pump stays off
    send_item(ModeMeasure, 16'd21, 1'b0, 1'b1);     // pump starts
    send_item(ModeMeasure, 16'd24, 1'b0, 1'b1);
    send_item(ModeMeasure, 16'd96, 1'b0, 1'b1);
    send_item(ModeMeasure, 16'd100, 1'b1, 1'b1);
    send_item(ModeMeasure, 16'd176, 1'b0, 1'b1);
    send_item(ModeMeasure, 16'd180, 1'b0, 1'b1);
    send_item(ModeMeasure, 16'd260, 1'b0, 1'b0);
    send_item(ModeMeasure, 16'd340, 1'b1, 1'b0);
    send_item(ModeMeasure, 16'd380, 1'b0, 1'b1);
    send_item(ModeMeasure, 16'd384, 1'b0, 1'b1);
    send_item(ModeMeasure, 16'd416, 1'b0, 1'b1);
    send_item(ModeMeasure, 16'd420, 1'b0, 1'b0);    // empty
    send_item(ModeMeasure, 16'd421, 1'b1, 1'b1);    // clamped to the full tank depth
    send_item(ModeTick, 16'hAAAA, 1'b0, 1'b1);
    send_item(ModeMeasure, 16'hFFFF, 1'b1, 1'b1);
    send_item(ModeTick, 16'h5555, 1'b1, 1'b0);

    for (int s = 0; s < 12; s++) begin
      drain();
      write_levels((set_h[s] < 0) ? $urandom_range(1, 1000) : set_h[s],
                   (set_g[s] < 0) ? $urandom_range(0, 1000) : set_g[s]);
      case (s % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 55; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      if (s == 4) hold_req <= 1'b1;
      random_items(70);
      if (s % 3 == 1) drain();
      random_items(70);
    end

    drain();
    repeat (25) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
